// ===== rtl/core/sql_text_tokenizer_defines.svh =====
// sql_text_tokenizer_defines.svh: assertion macros for the tokenizer.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SQL_TEXT_TOKENIZER_DEFINES_SVH
`define SQL_TEXT_TOKENIZER_DEFINES_SVH

// plain invariant, checked at every clock edge out of reset
`define SQLTOK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define SQLTOK_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sqltok_pkg.sv =====
// sqltok_pkg: result item type, token kind and status codes, character constants.
// No dependencies; used by the lexer, the result queue and the top level.
package sqltok_pkg;

	localparam logic [2:0] KIND_WORD   = 3'd0;
	localparam logic [2:0] KIND_NUMBER = 3'd1;
	localparam logic [2:0] KIND_STRING = 3'd2;
	localparam logic [2:0] KIND_PARAM  = 3'd3;
	localparam logic [2:0] KIND_PUNCT  = 3'd4;
	localparam logic [2:0] KIND_OPER   = 3'd5;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_BAD_CHAR   = 2'd1;
	localparam logic [1:0] STATUS_OPEN_QUOTE = 2'd2;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_QMARK   = 8'h3F;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_DOT     = 8'h2E;

	// result queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = QPTR_BITS + 1;

	typedef struct packed {
		logic [2:0]  kind;
		logic        token_start;
		logic        token_end;
		logic        has_char;
		logic [7:0]  char_out;
		logic [15:0] line;
		logic [15:0] column;
		logic [1:0]  status;
		logic        text_done;
		logic        last_of_run;
	} result_t;

endpackage

// ===== rtl/core/sqltok_lexer.sv =====
// sqltok_lexer: lexer state registers and the single-step next-state/result logic.
// Depends on sqltok_pkg. Gives up to two result items per step.
module sqltok_lexer #(
	parameter int POS_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 command,
	input  logic [7:0]           char_in,
	output logic [1:0]           res_count,
	output sqltok_pkg::result_t  res0,
	output sqltok_pkg::result_t  res1
);
	import sqltok_pkg::*;

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_WORD   = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_SQUOTE = 3'd3;
	localparam logic [2:0] MODE_DQUOTE = 3'd4;
	localparam logic [2:0] MODE_ERROR  = 3'd5;

	localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
	localparam logic [POS_BITS-1:0] OUT_MAX = POS_BITS'(17'h0FFFF);

	logic [2:0]          mode_q, mode_d;
	logic [POS_BITS-1:0] cur_line_q, cur_line_d, cur_col_q, cur_col_d;
	logic [POS_BITS-1:0] start_line_q, start_line_d, start_col_q, start_col_d;

	function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] v);
		return (v == POS_MAX) ? v : v + POS_ONE;
	endfunction

	// clamp to the 16-bit output field
	function automatic logic [15:0] sat16(input logic [POS_BITS-1:0] v);
		return (v > OUT_MAX) ? 16'hFFFF : 16'(v);
	endfunction

	function automatic result_t mk(input logic [2:0] kind, input logic st, input logic en,
			input logic hc, input logic [7:0] ch, input logic [POS_BITS-1:0] ln,
			input logic [POS_BITS-1:0] col, input logic [1:0] status, input logic done);
		result_t r;
		r.kind        = kind;
		r.token_start = st;
		r.token_end   = en;
		r.has_char    = hc;
		r.char_out    = hc ? ch : 8'h00;
		r.line        = sat16(ln);
		r.column      = sat16(col);
		r.status      = status;
		r.text_done   = done;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	logic is_alpha, is_digit, is_space, is_punct, is_oper;
	assign is_alpha = (char_in inside {[8'h61:8'h7A], [8'h41:8'h5A]});
	assign is_digit = (char_in inside {[8'h30:8'h39]});
	assign is_space = (char_in == CH_SPACE) || (char_in inside {[8'h09:8'h0D]});
	assign is_punct = (char_in inside {8'h28, 8'h29, 8'h2C, 8'h3B});
	assign is_oper  = (char_in inside {8'h3D, 8'h3C, 8'h3E, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25});

	// lexing of a byte from idle, shared by the idle case and the word/number end case
	logic                id_emit;
	logic [2:0]          id_mode;
	logic [POS_BITS-1:0] id_line, id_col, id_sline, id_scol;
	result_t             id_res;

	always_comb begin
		id_emit  = 1'b1;
		id_mode  = MODE_IDLE;
		id_line  = cur_line_q;
		id_col   = pos_inc(cur_col_q);
		id_sline = cur_line_q;
		id_scol  = cur_col_q;
		id_res   = mk(KIND_WORD, 1'b1, 1'b0, 1'b1, char_in, cur_line_q, cur_col_q,
				STATUS_OK, 1'b0);
		if (is_space) begin
			id_emit  = 1'b0;
			id_sline = start_line_q;
			id_scol  = start_col_q;
			if (char_in == CH_NEWLINE) begin
				id_line = pos_inc(cur_line_q);
				id_col  = POS_ONE;
			end
		end else if (is_alpha || char_in == CH_UNDER) begin
			id_mode = MODE_WORD;
		end else if (is_digit) begin
			id_mode     = MODE_NUMBER;
			id_res.kind = KIND_NUMBER;
		end else if (char_in == CH_SQUOTE) begin
			id_mode = MODE_SQUOTE;
			id_res  = mk(KIND_STRING, 1'b1, 1'b0, 1'b0, char_in, cur_line_q, cur_col_q,
					STATUS_OK, 1'b0);
		end else if (char_in == CH_DQUOTE) begin
			id_mode = MODE_DQUOTE;
			id_res  = mk(KIND_WORD, 1'b1, 1'b0, 1'b0, char_in, cur_line_q, cur_col_q,
					STATUS_OK, 1'b0);
		end else if (char_in == CH_QMARK) begin
			id_res.kind      = KIND_PARAM;
			id_res.token_end = 1'b1;
		end else if (is_punct || is_oper) begin
			id_res.kind      = is_punct ? KIND_PUNCT : KIND_OPER;
			id_res.token_end = 1'b1;
		end else begin
			id_mode = MODE_ERROR;
			id_col  = cur_col_q;
			id_res  = mk(KIND_WORD, 1'b0, 1'b0, 1'b0, char_in, cur_line_q, cur_col_q,
					STATUS_BAD_CHAR, 1'b0);
		end
	end

	logic [2:0] kind_wn, kind_quote;
	logic       more_wn;
	logic [7:0] quote_ch;
	assign kind_wn    = (mode_q == MODE_WORD) ? KIND_WORD : KIND_NUMBER;
	assign more_wn    = (mode_q == MODE_WORD) ? (is_alpha || is_digit || char_in == CH_UNDER)
			: (is_digit || char_in == CH_DOT);
	assign quote_ch   = (mode_q == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
	assign kind_quote = (mode_q == MODE_SQUOTE) ? KIND_STRING : KIND_WORD;

	always_comb begin
		mode_d       = mode_q;
		cur_line_d   = cur_line_q;
		cur_col_d    = cur_col_q;
		start_line_d = start_line_q;
		start_col_d  = start_col_q;
		res_count    = 2'd0;
		res0         = '0;
		res1         = '0;
		if (command) begin
			res_count = 2'd1;
			case (mode_q)
				MODE_WORD, MODE_NUMBER: begin
					res0 = mk(kind_wn, 1'b0, 1'b1, 1'b0, char_in, start_line_q, start_col_q,
							STATUS_OK, 1'b1);
				end
				MODE_SQUOTE, MODE_DQUOTE: begin
					res0 = mk(KIND_WORD, 1'b0, 1'b0, 1'b0, char_in, start_line_q,
							start_col_q, STATUS_OPEN_QUOTE, 1'b1);
				end
				default: begin
					res0 = mk(KIND_WORD, 1'b0, 1'b0, 1'b0, char_in, cur_line_q, cur_col_q,
							STATUS_OK, 1'b1);
				end
			endcase
			mode_d       = MODE_IDLE;
			cur_line_d   = POS_ONE;
			cur_col_d    = POS_ONE;
			start_line_d = POS_ONE;
			start_col_d  = POS_ONE;
		end else begin
			case (mode_q)
				MODE_WORD, MODE_NUMBER: begin
					if (more_wn) begin
						res_count = 2'd1;
						res0 = mk(kind_wn, 1'b0, 1'b0, 1'b1, char_in, start_line_q,
								start_col_q, STATUS_OK, 1'b0);
						cur_col_d = pos_inc(cur_col_q);
					end else begin
						// end marker, then the byte is lexed from idle
						res_count    = id_emit ? 2'd2 : 2'd1;
						res0 = mk(kind_wn, 1'b0, 1'b1, 1'b0, char_in, start_line_q,
								start_col_q, STATUS_OK, 1'b0);
						res1         = id_res;
						mode_d       = id_mode;
						cur_line_d   = id_line;
						cur_col_d    = id_col;
						start_line_d = id_sline;
						start_col_d  = id_scol;
					end
				end
				MODE_SQUOTE, MODE_DQUOTE: begin
					res_count = 2'd1;
					cur_col_d = pos_inc(cur_col_q);
					if (char_in == quote_ch) begin
						mode_d = MODE_IDLE;
						res0 = mk(kind_quote, 1'b0, 1'b1, 1'b0, char_in, start_line_q,
								start_col_q, STATUS_OK, 1'b0);
					end else begin
						res0 = mk(kind_quote, 1'b0, 1'b0, 1'b1, char_in, start_line_q,
								start_col_q, STATUS_OK, 1'b0);
					end
				end
				MODE_IDLE: begin
					res_count    = id_emit ? 2'd1 : 2'd0;
					res0         = id_res;
					mode_d       = id_mode;
					cur_line_d   = id_line;
					cur_col_d    = id_col;
					start_line_d = id_sline;
					start_col_d  = id_scol;
				end
				default: begin
					// error: swallow bytes until end of text
				end
			endcase
		end
		if (res_count == 2'd1)
			res0.last_of_run = 1'b1;
		if (res_count == 2'd2)
			res1.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			cur_line_q   <= POS_ONE;
			cur_col_q    <= POS_ONE;
			start_line_q <= POS_ONE;
			start_col_q  <= POS_ONE;
		end else if (step) begin
			mode_q       <= mode_d;
			cur_line_q   <= cur_line_d;
			cur_col_q    <= cur_col_d;
			start_line_q <= start_line_d;
			start_col_q  <= start_col_d;
		end
	end

endmodule

// ===== rtl/core/sqltok_queue.sv =====
// sqltok_queue: four-entry result queue, takes zero, one or two items per cycle.
// Depends on sqltok_pkg.
module sqltok_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [1:0]                       push_count,
	input  sqltok_pkg::result_t              push0,
	input  sqltok_pkg::result_t              push1,
	input  logic                             pop,
	output sqltok_pkg::result_t              head,
	output logic [sqltok_pkg::QCNT_BITS-1:0] count
);
	import sqltok_pkg::*;

	result_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push_count != 2'd0)
			mem_q[wr_ptr_q] <= push0;
		if (push_count == 2'd2)
			mem_q[wr_ptr_q + QPTR_BITS'(1)] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_BITS'(push_count);
			rd_ptr_q <= rd_ptr_q + QPTR_BITS'(pop);
			count_q  <= count_q + QCNT_BITS'(push_count) - QCNT_BITS'(pop);
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign count = count_q;

endmodule

// ===== rtl/core/sql_text_tokenizer.sv =====
// sql_text_tokenizer: top level of the streaming SQL tokenizer.
// Depends on sqltok_pkg, sqltok_lexer, sqltok_queue and sql_text_tokenizer_defines.svh.
//
// Use:
//  - Input channel (valid, stall, command, char_in): one item per text byte
//    (command 0) or an end-of-text command (command 1). Taken when valid is
//    high and stall is low.
//  - Result channel (res_valid, res_stall, kind ... last_of_run): one token
//    fragment per item; a token is a start item, its text bytes, an end item.
//  - Path: an accepted item is held in the input register and lexed from
//    there once the queue has room; its results go to the result queue.
//  - Throughput: one input item per cycle while results drain. A byte that
//    ends a word or number can give two results; the result port sends one
//    per cycle, so the second result waits in the queue. The four-entry
//    result queue and its count set when the lexer may step.
//  - Stall: when res_stall is held, the queue fills, the lexer holds its
//    item and stall is raised toward the sender. Nothing is dropped.
//  - Reset: queue empty, lexer idle, line and column back to 1.
//  - Tokens sent before an error result are not withdrawn; the consumer
//    discards them.
`include "sql_text_tokenizer_defines.svh"

module sql_text_tokenizer #(
	parameter int POS_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        valid,
	output logic        stall,
	input  logic        command,
	input  logic [7:0]  char_in,
	// result items
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  kind,
	output logic        token_start,
	output logic        token_end,
	output logic        has_char,
	output logic [7:0]  char_out,
	output logic [15:0] line,
	output logic [15:0] column,
	output logic [1:0]  status,
	output logic        text_done,
	output logic        last_of_run
);
	import sqltok_pkg::*;

	localparam int CNT_BITS = QCNT_BITS;

	// input register
	logic       valid_s1;
	logic       command_s1;
	logic [7:0] char_s1;

	// lexer step and queue status
	logic                lex_step;
	logic                room;
	logic [1:0]          lex_count;
	result_t             lex_res0, lex_res1, head;
	logic [CNT_BITS-1:0] q_count;
	logic                pop;

	// step only when the queue can take the worst case of two results
	assign room     = (q_count <= CNT_BITS'(QUEUE_DEPTH - 2));
	assign lex_step = valid_s1 && room;
	assign stall    = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (valid && !stall) begin
			command_s1 <= command;
			char_s1    <= char_in;
		end
	end

	sqltok_lexer #(
		.POS_BITS(POS_BITS)
	) u_lexer (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (lex_step),
		.command  (command_s1),
		.char_in  (char_s1),
		.res_count(lex_count),
		.res0     (lex_res0),
		.res1     (lex_res1)
	);

	sqltok_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_count(lex_step ? lex_count : 2'd0),
		.push0     (lex_res0),
		.push1     (lex_res1),
		.pop       (pop),
		.head      (head),
		.count     (q_count)
	);

	assign res_valid   = (q_count != '0);
	assign pop         = res_valid && !res_stall;

	assign kind        = head.kind;
	assign token_start = head.token_start;
	assign token_end   = head.token_end;
	assign has_char    = head.has_char;
	assign char_out    = head.char_out;
	assign line        = head.line;
	assign column      = head.column;
	assign status      = head.status;
	assign text_done   = head.text_done;
	assign last_of_run = head.last_of_run;

	// queue never overfills
	`SQLTOK_ASSERT(a_queue_bound, q_count <= CNT_BITS'(QUEUE_DEPTH), "result queue overflow")
	// only a text byte can give two results
	`SQLTOK_ASSERT_IMPL(a_two_only_byte, lex_step && lex_count == 2'd2, !command_s1,
		"two results from end of text")
	// end of text is always the last result of its item
	`SQLTOK_ASSERT_IMPL(a_done_last, res_valid && text_done, last_of_run,
		"text_done result not last of run")

endmodule
